FILE: sv/bgd_pkg.sv
// Shared types, constants and the exponent fraction table of the Gaussian density core.
package bgd_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int Q_CLAMP_W      = 23;
  localparam int LATENCY        = 9;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_INV_COV_XX = 3'd2,
    REG_INV_COV_XY = 3'd3,
    REG_INV_COV_YX = 3'd4,
    REG_INV_COV_YY = 3'd5,
    REG_PEAK_SCALE = 3'd6
  } bgd_reg_e;

  typedef struct packed {
    logic                 vld;
    logic                 neg;
    logic                 big;
    logic [Q_CLAMP_W-1:0] q;
  } bgd_quad_t;

  localparam logic [31:0] POW_FRAC [12] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
    32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
    32'd4289156796, 32'd4292061075, 32'd4293513940, 32'd4294240561
  };

  typedef logic [32:0] exp_tab_t [EXP_TABLE_SIZE];

  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [64:0] m;
    for (int idx = 0; idx < EXP_TABLE_SIZE; idx++) begin
      m = 65'd1 << 32;
      for (int k = 0; k < EXP_TABLE_BITS; k++) begin
        if (((idx >> (EXP_TABLE_BITS - 1 - k)) & 1) != 0) begin
          m = (m * {33'd0, POW_FRAC[k]} + 65'h0_8000_0000) >> 32;
        end
      end
      tab[idx] = m[32:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

FILE: sv/bivariate_gaussian_density_core.sv
// Top level of the bivariate Gaussian density core: register file and pipeline.
//
// Evaluates scale * exp(-q/2) of a 2-D Gaussian at one point per transfer.
// Command channel: an item is taken at a rising edge with start high and
// busy low; busy stays low, so a new point can be taken in every cycle.
// cmd selects the stored center (0) or the center carried with the point (1).
// Result channel: done is high for one cycle with density and clipped; the
// receiver has no way to hold it off and none is needed.
// Each point passes through the registered quadratic form and exponent stages;
// throughput is one item per cycle, set by the fully pipelined multipliers
// of the quadratic form and the exponent path.
// Configuration: wr_en with wr_index and wr_data writes one register at the
// edge; write only while no item is in flight. Unknown indexes are dropped.
// Reset (rst, synchronous) clears all pipeline valid bits and restores the
// register defaults: unit inverse covariance, zero center, unit scale.
module bivariate_gaussian_density_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic signed [31:0]                point_x,
  input  logic signed [31:0]                point_y,
  input  logic signed [31:0]                given_center_x,
  input  logic signed [31:0]                given_center_y,
  input  logic                              wr_en,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bgd_pkg::DATA_W-1:0]        wr_data,
  output logic                              done,
  output logic [31:0]                       density,
  output logic                              clipped
);
  import bgd_pkg::*;

  logic signed [31:0] center_x, center_y;
  logic signed [31:0] inv_cov_xx, inv_cov_xy, inv_cov_yx, inv_cov_yy;
  logic [31:0]        peak_scale;
  bgd_quad_t          quad;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      inv_cov_xx <= 32'sd16777216;
      inv_cov_xy <= '0;
      inv_cov_yx <= '0;
      inv_cov_yy <= 32'sd16777216;
      peak_scale <= 32'd65536;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_X:   center_x   <= wr_data;
        REG_CENTER_Y:   center_y   <= wr_data;
        REG_INV_COV_XX: inv_cov_xx <= wr_data;
        REG_INV_COV_XY: inv_cov_xy <= wr_data;
        REG_INV_COV_YX: inv_cov_yx <= wr_data;
        REG_INV_COV_YY: inv_cov_yy <= wr_data;
        REG_PEAK_SCALE: peak_scale <= wr_data;
        default: ;
      endcase
    end
  end

  bgd_quad u_quad (
    .clk            (clk),
    .rst            (rst),
    .in_vld         (start && !busy),
    .cmd            (cmd),
    .point_x        (point_x),
    .point_y        (point_y),
    .given_center_x (given_center_x),
    .given_center_y (given_center_y),
    .center_x       (center_x),
    .center_y       (center_y),
    .inv_cov_xx     (inv_cov_xx),
    .inv_cov_xy     (inv_cov_xy),
    .inv_cov_yx     (inv_cov_yx),
    .inv_cov_yy     (inv_cov_yy),
    .q_out          (quad)
  );

  bgd_exp u_exp (
    .clk        (clk),
    .rst        (rst),
    .q_in       (quad),
    .peak_scale (peak_scale),
    .done       (done),
    .density    (density),
    .clipped    (clipped)
  );

endmodule

FILE: sv/bgd_quad.sv
// Quadratic form pipeline: offsets, squared products and weighted sum q.
module bgd_quad (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic                         cmd,
  input  logic signed [31:0]           point_x,
  input  logic signed [31:0]           point_y,
  input  logic signed [31:0]           given_center_x,
  input  logic signed [31:0]           given_center_y,
  input  logic signed [31:0]           center_x,
  input  logic signed [31:0]           center_y,
  input  logic signed [31:0]           inv_cov_xx,
  input  logic signed [31:0]           inv_cov_xy,
  input  logic signed [31:0]           inv_cov_yx,
  input  logic signed [31:0]           inv_cov_yy,
  output bgd_pkg::bgd_quad_t           q_out
);
  import bgd_pkg::*;

  function automatic logic signed [31:0] sat_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // stage 1
  logic               s1_vld;
  logic signed [31:0] s1_dx, s1_dy;
  logic signed [31:0] cx, cy;

  assign cx = cmd ? given_center_x : center_x;
  assign cy = cmd ? given_center_y : center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    s1_dx <= sat_diff(point_x, cx);
    s1_dy <= sat_diff(point_y, cy);
  end

  // stage 2
  logic        s2_vld;
  logic [46:0] s2_pxx, s2_pyy, s2_pxy;
  logic        s2_sxy;
  logic [63:0] prod_xx, prod_yy, prod_xy;

  assign prod_xx = mag32(s1_dx) * mag32(s1_dx);
  assign prod_yy = mag32(s1_dy) * mag32(s1_dy);
  assign prod_xy = mag32(s1_dx) * mag32(s1_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_pxx <= prod_xx[62:16];
    s2_pyy <= prod_yy[62:16];
    s2_pxy <= prod_xy[62:16];
    s2_sxy <= s1_dx[31] ^ s1_dy[31];
  end

  // stage 3
  logic signed [32:0] cross_k;
  logic [32:0]        mk_xx, mk_yy, mk_xy;
  logic [56:0]        lo_xx, lo_yy, lo_xy;
  logic               s3_vld;
  logic [55:0]        s3_hi_xx, s3_hi_yy, s3_hi_xy;
  logic [32:0]        s3_lo_xx, s3_lo_yy, s3_lo_xy;
  logic               s3_n_xx, s3_n_yy, s3_n_xy;

  assign cross_k = {inv_cov_xy[31], inv_cov_xy} + {inv_cov_yx[31], inv_cov_yx};
  assign mk_xx = mag33({inv_cov_xx[31], inv_cov_xx});
  assign mk_yy = mag33({inv_cov_yy[31], inv_cov_yy});
  assign mk_xy = mag33(cross_k);
  assign lo_xx = s2_pxx[23:0] * mk_xx;
  assign lo_yy = s2_pyy[23:0] * mk_yy;
  assign lo_xy = s2_pxy[23:0] * mk_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_hi_xx <= s2_pxx[46:24] * mk_xx;
    s3_hi_yy <= s2_pyy[46:24] * mk_yy;
    s3_hi_xy <= s2_pxy[46:24] * mk_xy;
    s3_lo_xx <= lo_xx[56:24];
    s3_lo_yy <= lo_yy[56:24];
    s3_lo_xy <= lo_xy[56:24];
    s3_n_xx  <= inv_cov_xx[31];
    s3_n_yy  <= inv_cov_yy[31];
    s3_n_xy  <= s2_sxy ^ cross_k[32];
  end

  // stage 4
  logic [56:0]        r_xx, r_yy, r_xy;
  logic               s4_vld;
  logic signed [57:0] s4_t_xx, s4_t_yy, s4_t_xy;

  assign r_xx = {1'b0, s3_hi_xx} + {24'd0, s3_lo_xx};
  assign r_yy = {1'b0, s3_hi_yy} + {24'd0, s3_lo_yy};
  assign r_xy = {1'b0, s3_hi_xy} + {24'd0, s3_lo_xy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_t_xx <= s3_n_xx ? -$signed({1'b0, r_xx}) : $signed({1'b0, r_xx});
    s4_t_yy <= s3_n_yy ? -$signed({1'b0, r_yy}) : $signed({1'b0, r_yy});
    s4_t_xy <= s3_n_xy ? -$signed({1'b0, r_xy}) : $signed({1'b0, r_xy});
  end

  // stage 5
  logic signed [59:0] qsum;

  assign qsum = 60'(s4_t_xx) + 60'(s4_t_yy) + 60'(s4_t_xy);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.vld <= 1'b0;
    end else begin
      q_out.vld <= s4_vld;
    end
    q_out.neg <= qsum[59];
    q_out.big <= !qsum[59] && (qsum[58:Q_CLAMP_W] != '0);
    q_out.q   <= qsum[59] ? '0 : qsum[Q_CLAMP_W-1:0];
  end

endmodule

FILE: sv/bgd_exp.sv
// Exponential pipeline: base-2 exponent split, fraction table, scale and shift.
module bgd_exp (
  input  logic                         clk,
  input  logic                         rst,
  input  bgd_pkg::bgd_quad_t           q_in,
  input  logic [31:0]                  peak_scale,
  output logic                         done,
  output logic [31:0]                  density,
  output logic                         clipped
);
  import bgd_pkg::*;

  // stage 6
  logic [53:0]               t_prod;
  logic                      s6_vld, s6_neg, s6_big;
  logic [6:0]                s6_n;
  logic [EXP_TABLE_BITS-1:0] s6_idx;

  assign t_prod = q_in.q * LOG2E_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= q_in.vld;
    end
    s6_neg <= q_in.neg;
    s6_big <= q_in.big;
    s6_n   <= t_prod[53:47];
    s6_idx <= t_prod[46 -: EXP_TABLE_BITS];
  end

  // stage 7
  logic        s7_vld, s7_neg, s7_zero;
  logic [4:0]  s7_sh;
  logic [32:0] s7_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
    s7_neg  <= s6_neg;
    s7_zero <= s6_big || (s6_n[6:5] != 2'b00);
    s7_sh   <= s6_n[4:0];
    s7_m    <= EXP_TABLE[s6_idx];
  end

  // stage 8
  logic [64:0] pm;
  logic        s8_vld, s8_neg, s8_zero;
  logic [4:0]  s8_sh;
  logic [31:0] s8_hi;

  assign pm = peak_scale * s7_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= s7_vld;
    end
    s8_neg  <= s7_neg;
    s8_zero <= s7_zero;
    s8_sh   <= s7_sh;
    s8_hi   <= pm[63:32];
  end

  // stage 9
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8_vld;
    end
    density <= s8_zero ? '0 : (s8_hi >> s8_sh);
    clipped <= s8_neg;
  end

endmodule

FILE: sv/bgd_checker.sv
// Port-level checker for the Gaussian density core, bound to the top level.
module bgd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import bgd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transfer without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transfer");

endmodule

bind bivariate_gaussian_density_core bgd_checker u_bgd_checker (.*);
